### rtl/core/cpe_pkg.sv
package cpe_pkg;

  localparam int MAX_TERMS_DEF = 6;
  localparam int FRAC_BITS_DEF = 16;

  localparam int DATA_W      = 32;
  localparam int ACC_W       = 64;
  localparam int TC_W        = 3;
  localparam int CFG_INDEX_W = 3;
  localparam int COEFF_REGS  = 6;

  localparam logic [CFG_INDEX_W-1:0] REG_TERM_COUNT = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_COEFF_BASE = 3'd1;

  localparam logic signed [ACC_W-1:0] S32_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [ACC_W-1:0] S32_MIN = 64'shFFFF_FFFF_8000_0000;

  typedef struct packed {
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] power;
    logic signed [ACC_W-1:0]  acc;
    logic                     ovf;
  } pipe_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     ovf;
  } sat_t;

  function automatic sat_t sat32(input logic signed [ACC_W-1:0] v);
    sat_t r;
    if (v > S32_MAX) begin
      r.value = S32_MAX[DATA_W-1:0];
      r.ovf   = 1'b1;
    end else if (v < S32_MIN) begin
      r.value = S32_MIN[DATA_W-1:0];
      r.ovf   = 1'b1;
    end else begin
      r.value = v[DATA_W-1:0];
      r.ovf   = 1'b0;
    end
    return r;
  endfunction

endpackage

### rtl/core/cpe_term.sv
module cpe_term #(
  parameter int FRAC_BITS = cpe_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                load_a,
  input  logic                                load_b,
  input  logic                                add_term,
  input  logic                                upd_power,
  input  logic signed [cpe_pkg::DATA_W-1:0]   coeff,
  input  cpe_pkg::pipe_t                      pipe_in,
  output cpe_pkg::pipe_t                      pipe_out
);

  logic signed [cpe_pkg::DATA_W-1:0] a_x;
  logic signed [cpe_pkg::ACC_W-1:0]  a_mul_p;
  logic signed [cpe_pkg::ACC_W-1:0]  a_mul_t;
  logic signed [cpe_pkg::ACC_W-1:0]  a_acc;
  logic                              a_ovf;

  logic signed [cpe_pkg::ACC_W-1:0]  p_shift;
  logic signed [cpe_pkg::ACC_W-1:0]  t_shift;
  cpe_pkg::sat_t                     p_sat;

  always_ff @(posedge clk) begin
    if (load_a) begin
      a_x     <= pipe_in.x;
      a_mul_p <= pipe_in.power * pipe_in.x;
      a_mul_t <= coeff * pipe_in.power;
      a_acc   <= pipe_in.acc;
      a_ovf   <= pipe_in.ovf;
    end
  end

  always_comb begin
    p_shift = a_mul_p >>> FRAC_BITS;
    t_shift = a_mul_t >>> FRAC_BITS;
    p_sat   = cpe_pkg::sat32(p_shift);
  end

  always_ff @(posedge clk) begin
    if (load_b) begin
      pipe_out.x     <= a_x;
      pipe_out.power <= p_sat.value;
      pipe_out.acc   <= add_term ? a_acc + t_shift : a_acc;
      pipe_out.ovf   <= a_ovf | (upd_power & p_sat.ovf);
    end
  end

endmodule

### rtl/core/calibration_polynomial_eval_core.sv
// Calibration polynomial evaluator. Each request on the input channel carries one
// signed Q16.16 sample x and produces exactly one result request with the value
// coeff_0 + coeff_1*x + ... + coeff_(n-1)*x^(n-1), saturated to 32 bits, and a flag
// that is set when a running power of x or the final sum saturated.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) writes
// term_count at index 0 and coeff_0 to coeff_5 at indexes 1 to 6; cfg_ready is always
// high, and other indexes are ignored. Configuration must only change while the
// pipeline is empty.
// The datapath is a pipeline of two register stages per term plus an output register,
// and a new sample can enter in every cycle while in_stall is low. The two multipliers
// of each term set the stage boundaries.
// When out_stall is high the output register holds its request, and stages behind it
// keep moving until they fill; in_stall rises only when the first stage is full and
// cannot advance. Nothing is lost or repeated.
// Reset clears all valid bits, sets term_count to one and all coefficients to zero.
module calibration_polynomial_eval_core #(
  parameter int MAX_TERMS = cpe_pkg::MAX_TERMS_DEF,
  parameter int FRAC_BITS = cpe_pkg::FRAC_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [cpe_pkg::DATA_W-1:0]      sample,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [cpe_pkg::DATA_W-1:0]      calibrated,
  output logic                                   overflow,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [cpe_pkg::CFG_INDEX_W-1:0]        cfg_index,
  input  logic [cpe_pkg::DATA_W-1:0]             cfg_data
);

  localparam int NS = 2 * MAX_TERMS;

  logic [cpe_pkg::TC_W-1:0]          term_count;
  logic [cpe_pkg::TC_W-1:0]          n_eff;
  logic signed [cpe_pkg::DATA_W-1:0] coeff [MAX_TERMS];

  logic [NS-1:0]                     v;
  logic [NS:0]                       en;
  logic [MAX_TERMS-1:0]              add_term;
  logic [MAX_TERMS-1:0]              upd_power;

  cpe_pkg::pipe_t                    pipe [MAX_TERMS+1];
  cpe_pkg::sat_t                     fin;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      term_count <= cpe_pkg::TC_W'(1);
    end else if (cfg_valid && cfg_index == cpe_pkg::REG_TERM_COUNT) begin
      term_count <= cfg_data[cpe_pkg::TC_W-1:0];
    end
  end

  genvar k;
  generate
    for (k = 0; k < MAX_TERMS; k++) begin : g_coeff
      if (k < cpe_pkg::COEFF_REGS) begin : g_reg
        always_ff @(posedge clk) begin
          if (rst) begin
            coeff[k] <= '0;
          end else if (cfg_valid &&
                       cfg_index == cpe_pkg::REG_COEFF_BASE + cpe_pkg::CFG_INDEX_W'(k)) begin
            coeff[k] <= cfg_data;
          end
        end
      end else begin : g_zero
        assign coeff[k] = '0;
      end
    end
  endgenerate

  always_comb begin
    if (term_count == '0) begin
      n_eff = cpe_pkg::TC_W'(1);
    end else if (term_count > cpe_pkg::TC_W'(MAX_TERMS)) begin
      n_eff = cpe_pkg::TC_W'(MAX_TERMS);
    end else begin
      n_eff = term_count;
    end
  end

  always_comb begin
    en[NS] = !out_valid || !out_stall;
    for (int i = NS - 1; i >= 0; i--) begin
      en[i] = !v[i] || en[i+1];
    end
  end

  assign in_stall = !en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v         <= '0;
      out_valid <= 1'b0;
    end else begin
      if (en[0]) begin
        v[0] <= in_valid;
      end
      for (int i = 1; i < NS; i++) begin
        if (en[i]) begin
          v[i] <= v[i-1];
        end
      end
      if (en[NS]) begin
        out_valid <= v[NS-1];
      end
    end
  end

  always_comb begin
    pipe[0].x     = sample;
    pipe[0].power = cpe_pkg::DATA_W'(1) << FRAC_BITS;
    pipe[0].acc   = cpe_pkg::ACC_W'(coeff[0]);
    pipe[0].ovf   = 1'b0;
  end

  genvar j;
  generate
    for (j = 0; j < MAX_TERMS; j++) begin : g_term
      assign add_term[j]  = (j != 0) && (cpe_pkg::TC_W'(j) < n_eff);
      assign upd_power[j] = (cpe_pkg::TC_W'(j + 1) < n_eff);

      cpe_term #(
        .FRAC_BITS(FRAC_BITS)
      ) u_term (
        .clk      (clk),
        .load_a   (en[2*j]),
        .load_b   (en[2*j+1]),
        .add_term (add_term[j]),
        .upd_power(upd_power[j]),
        .coeff    (coeff[j]),
        .pipe_in  (pipe[j]),
        .pipe_out (pipe[j+1])
      );
    end
  endgenerate

  assign fin = cpe_pkg::sat32(pipe[MAX_TERMS].acc);

  always_ff @(posedge clk) begin
    if (en[NS]) begin
      calibrated <= fin.value;
      overflow   <= pipe[MAX_TERMS].ovf | fin.ovf;
    end
  end

endmodule

### rtl/core/cpe_checker.sv
module cpe_assertions #(
  parameter int MAX_TERMS = cpe_pkg::MAX_TERMS_DEF
) (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic signed [cpe_pkg::DATA_W-1:0] calibrated,
  input logic                              overflow
);

  localparam int DEPTH = 2 * MAX_TERMS + 1;
  localparam int CNT_W = $clog2(DEPTH + 2);

  logic [CNT_W-1:0] inflight;
  logic             in_acc;
  logic             out_acc;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else if (in_acc && !out_acc) begin
      inflight <= inflight + CNT_W'(1);
    end else if (out_acc && !in_acc) begin
      inflight <= inflight - CNT_W'(1);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(calibrated) && $stable(overflow))
    else $error("result changed while stalled");

  a_empty_out_no_stall: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled while output register is empty");

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    out_acc |-> inflight != '0)
    else $error("result without a pending request");

  a_depth: assert property (@(posedge clk) disable iff (rst)
    inflight <= CNT_W'(DEPTH))
    else $error("more requests in flight than pipeline stages");

endmodule

bind calibration_polynomial_eval_core cpe_assertions #(
  .MAX_TERMS(MAX_TERMS)
) u_cpe_checker (.*);
